### hw/rtl/assert_macros.svh
// Assertion helpers used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define MLT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/mlt_pkg.sv
// ----------------------------------------------------------------------------
// MAC learning table package
// Request and result types, command codes, slot layout, hash constants and
// the staleness rule used by the table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mlt_pkg;

    // Command codes of a request.
    typedef enum logic [1:0] {
        CMD_LEARN  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_AGE    = 2'd2,
        CMD_NOP    = 2'd3
    } mlt_cmd_t;

    // One request as it arrives.
    typedef struct packed {
        logic [1:0]  command;
        logic [47:0] mac_address;
        logic [15:0] port_in;
        logic [31:0] time_now;
    } mlt_in_t;

    // One result as it leaves.
    typedef struct packed {
        logic        ok;
        logic [15:0] port_out;
        logic [12:0] removed_count;
        logic [12:0] entry_count;
    } mlt_out_t;

    // One table slot as stored in memory.
    typedef struct packed {
        logic        valid;
        logic [47:0] mac;
        logic [15:0] port;
        logic [31:0] stamp;
    } mlt_slot_t;

    // Status from the back end to the front end.
    typedef struct packed {
        logic clear_done;
    } mlt_status_t;

    // Front end sequencer.
    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_REDUCE,
        F_PUSH
    } mlt_front_state_t;

    // Back end sequencer.
    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE,
        B_SWEEP
    } mlt_back_state_t;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam int unsigned REDUCE_STEPS = 8;
    localparam int unsigned HASH_BYTES = 6;

    // An entry is stale when it is older than now by more than the limit.
    function automatic logic is_stale(input logic [31:0] now,
                                      input logic [31:0] stamp,
                                      input logic [31:0] limit);
        logic [31:0] diff;
        diff = now - stamp;
        return (now > stamp) && (diff > limit);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/mlt_queue.sv
// ----------------------------------------------------------------------------
// MAC learning table request queue
// Two-entry FIFO between the hashing front end and the table back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mlt_queue
#(
    parameter int unsigned ITEM_W = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire logic [ITEM_W-1:0] push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output logic [ITEM_W-1:0]      pop_data
);

    logic [ITEM_W-1:0] buf_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        fill_reg;
    logic [1:0]        fill_next;
    logic              do_push;
    logic              do_pop;

    // Handshake decode.
    always_comb
    begin
        push_ready = (fill_reg != 2'd2);
        pop_valid  = (fill_reg != 2'd0);
        pop_data   = buf_reg[rd_ptr_reg];
        do_push    = push_valid && push_ready;
        do_pop     = pop_valid && pop_ready;
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mlt_front.sv
// ----------------------------------------------------------------------------
// MAC learning table front end
// Accepts requests, computes the FNV-1a hash one byte per cycle and reduces
// it to a start slot, then hands the request to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mlt_front
    import mlt_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = 4096,
    parameter int unsigned IDX_W = 12
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mlt_status_t       status,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mlt_in_t           in_data,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output mlt_in_t                push_item,
    output logic [IDX_W-1:0]       push_idx
);

    localparam bit IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam logic [IDX_W:0] SLOTS_W = (IDX_W + 1)'(TABLE_SLOTS);

    mlt_front_state_t state_reg;
    mlt_front_state_t state_next;
    mlt_in_t          item_reg;
    mlt_in_t          item_next;
    logic [31:0]      hash_reg;
    logic [31:0]      hash_next;
    logic [2:0]       step_reg;
    logic [2:0]       step_next;
    logic [IDX_W:0]   rem_reg;
    logic [IDX_W:0]   rem_next;
    logic [7:0]       cur_byte;
    logic [31:0]      mixed;
    logic [3:0]       nibble;
    logic [IDX_W:0]   rem_work;

    assign push_item = item_reg;
    assign push_idx  = rem_reg[IDX_W-1:0];

    // Byte and nibble selection for the current step.
    always_comb
    begin
        cur_byte = item_reg.mac_address[47 - 8 * step_reg -: 8];
        mixed    = hash_reg ^ {24'd0, cur_byte};
        nibble   = hash_reg[31 - 4 * step_reg -: 4];
        rem_work = rem_reg;
        for (int b = 3; b >= 0; b--)
        begin
            rem_work = {rem_work[IDX_W-1:0], nibble[b]};
            if (rem_work >= SLOTS_W)
            begin
                rem_work = rem_work - SLOTS_W;
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        hash_next  = hash_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        in_ready   = (state_reg == F_IDLE) && status.clear_done;
        push_valid = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    item_next  = in_data;
                    hash_next  = FNV_BASIS;
                    step_next  = 3'd0;
                    state_next = F_HASH;
                end
            end
            F_HASH:
            begin
                hash_next = mixed * FNV_PRIME;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'(HASH_BYTES - 1))
                begin
                    step_next = 3'd0;
                    rem_next  = '0;
                    if (IS_POW2)
                    begin
                        rem_next   = {1'b0, hash_next[IDX_W-1:0]};
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        state_next = F_REDUCE;
                    end
                end
            end
            F_REDUCE:
            begin
                rem_next  = rem_work;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'(REDUCE_STEPS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Request payload and hash.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        hash_reg <= hash_next;
        rem_reg  <= rem_next;
    end

endmodule

`default_nettype wire

### hw/rtl/mlt_back.sv
// ----------------------------------------------------------------------------
// MAC learning table back end
// Holds the slot memory, clears it after reset, probes it for learn and
// lookup requests, sweeps it for aging and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mlt_back
    import mlt_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = 4096,
    parameter int unsigned IDX_W = 12,
    parameter int unsigned CNT_W = 13
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_en,
    input  wire logic [31:0]       cfg_write_data,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire mlt_in_t           q_item,
    input  wire logic [IDX_W-1:0]  q_idx,
    output mlt_status_t            status,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mlt_out_t               out_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOTS_C  = CNT_W'(TABLE_SLOTS);

    mlt_slot_t        mem [TABLE_SLOTS];
    mlt_slot_t        rd_data_reg;

    mlt_back_state_t  state_reg;
    mlt_back_state_t  state_next;
    mlt_in_t          cur_reg;
    mlt_in_t          cur_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] pcnt_reg;
    logic [IDX_W-1:0] pcnt_next;
    logic [CNT_W-1:0] sweep_reg;
    logic [CNT_W-1:0] sweep_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] removed_reg;
    logic [CNT_W-1:0] removed_next;
    logic [IDX_W-1:0] clr_reg;
    logic [IDX_W-1:0] clr_next;
    logic [31:0]      age_limit_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    mlt_out_t         out_data_reg;
    mlt_out_t         out_data_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    mlt_slot_t        wr_data;
    logic             stop_here;
    logic             fresh;
    logic [CNT_W-1:0] sweep_prev;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign status.clear_done = (state_reg != B_CLEAR);

    // Probe and sweep decode of the slot just read.
    always_comb
    begin
        stop_here  = !rd_data_reg.valid || (rd_data_reg.mac == cur_reg.mac_address);
        fresh      = !is_stale(cur_reg.time_now, rd_data_reg.stamp, age_limit_reg);
        sweep_prev = sweep_reg - CNT_W'(1);
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        pcnt_next      = pcnt_reg;
        sweep_next     = sweep_reg;
        count_next     = count_reg;
        removed_next   = removed_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        q_ready        = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rd_data_reg;

        // The consumer takes the result.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_reg;
                wr_data       = '0;
                clr_next      = clr_reg + IDX_W'(1);
                if (clr_reg == LAST_IDX)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                q_ready = !out_valid_reg;
                if (q_valid && q_ready)
                begin
                    cur_next = q_item;
                    unique case (mlt_cmd_t'(q_item.command)) inside
                        CMD_LEARN, CMD_LOOKUP:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = q_idx;
                            idx_next   = q_idx;
                            pcnt_next  = '0;
                            state_next = B_PROBE;
                        end
                        CMD_AGE:
                        begin
                            sweep_next   = '0;
                            removed_next = '0;
                            state_next   = B_SWEEP;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                            out_data_next.entry_count = 13'(count_reg);
                        end
                    endcase
                end
            end
            B_PROBE:
            begin
                if (stop_here)
                begin
                    out_data_next = '0;
                    if (mlt_cmd_t'(cur_reg.command) == CMD_LEARN)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = idx_reg;
                        wr_data.valid = 1'b1;
                        wr_data.mac   = cur_reg.mac_address;
                        wr_data.port  = cur_reg.port_in;
                        wr_data.stamp = cur_reg.time_now;
                        if (!rd_data_reg.valid)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        out_data_next.ok = 1'b1;
                    end
                    else if (rd_data_reg.valid && fresh)
                    begin
                        out_data_next.ok       = 1'b1;
                        out_data_next.port_out = rd_data_reg.port;
                    end
                    out_data_next.entry_count = 13'(count_next);
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
                else if (pcnt_reg == LAST_IDX)
                begin
                    // Every slot holds another address: nothing usable.
                    out_data_next = '0;
                    out_data_next.entry_count = 13'(count_reg);
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
                else
                begin
                    idx_next  = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
                    pcnt_next = pcnt_reg + IDX_W'(1);
                    rd_en     = 1'b1;
                    rd_addr   = idx_next;
                end
            end
            B_SWEEP:
            begin
                // Read one slot ahead while checking the slot read before.
                if (sweep_reg != SLOTS_C)
                begin
                    rd_en   = 1'b1;
                    rd_addr = sweep_reg[IDX_W-1:0];
                end
                if (sweep_reg != '0 && rd_data_reg.valid && !fresh)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = sweep_prev[IDX_W-1:0];
                    wr_data.valid = 1'b0;
                    wr_data.stamp = '0;
                    count_next    = count_reg - CNT_W'(1);
                    removed_next  = removed_reg + CNT_W'(1);
                end
                sweep_next = sweep_reg + CNT_W'(1);
                if (sweep_reg == SLOTS_C)
                begin
                    out_data_next = '0;
                    out_data_next.removed_count = 13'(removed_next);
                    out_data_next.entry_count   = 13'(count_next);
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            age_limit_reg <= 32'd300;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                age_limit_reg <= cfg_write_data;
            end
        end
    end

    // Working registers and result payload.
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        idx_reg      <= idx_next;
        pcnt_reg     <= pcnt_next;
        sweep_reg    <= sweep_next;
        removed_reg  <= removed_next;
        out_data_reg <= out_data_next;
    end

    // Slot memory: one write and one registered read each cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mac_learning_table.sv
// A learn or lookup request is hashed, reduced to a start slot (with extra reduction steps
// when TABLE_SLOTS is not 2**n), queued, and then probed slot by slot before its result is offered.
// An age sweep reads one slot per cycle and offers its result after the last slot is checked.
// The front end takes a new request only after it has pushed the last one, and hashes it while
// the back end probes the one before.
// After reset a clearing pass over all TABLE_SLOTS slots runs before requests are taken.
// ----------------------------------------------------------------------------
// MAC learning table
// Hash front end, request queue and table back end with registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_learning_table
    import mlt_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [31:0] cfg_write_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire mlt_in_t     in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output mlt_out_t         out_data
);

    localparam int unsigned IDX_W  = $clog2(TABLE_SLOTS);
    localparam int unsigned CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam int unsigned ITEM_W = $bits(mlt_in_t) + IDX_W;

    mlt_status_t      status;
    logic             push_valid;
    logic             push_ready;
    mlt_in_t          push_item;
    logic [IDX_W-1:0] push_idx;
    logic             pop_valid;
    logic             pop_ready;
    logic [ITEM_W-1:0] pop_data;
    mlt_in_t          q_item;
    logic [IDX_W-1:0] q_idx;

    // Hashing front end.
    mlt_front #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .IDX_W(IDX_W)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .status(status),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_item(push_item),
        .push_idx(push_idx)
    );

    // Queue between the two halves.
    mlt_queue #(
        .ITEM_W(ITEM_W)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data({push_item, push_idx}),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_data(pop_data)
    );

    assign q_item = pop_data[ITEM_W-1:IDX_W];
    assign q_idx  = pop_data[IDX_W-1:0];

    // Table back end.
    mlt_back #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .IDX_W(IDX_W),
        .CNT_W(CNT_W)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .q_valid(pop_valid),
        .q_ready(pop_ready),
        .q_item(q_item),
        .q_idx(q_idx),
        .status(status),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

endmodule

`default_nettype wire

### hw/rtl/mlt_checker.sv
// ----------------------------------------------------------------------------
// MAC learning table port checker
// Watches the top-level ports for result stability, result consistency and a quiet reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mlt_checker
    import mlt_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_ready,
    input wire logic     out_valid,
    input wire logic     out_ready,
    input wire mlt_out_t out_data
);

    // A stalled result keeps its value.
    `MLT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

    // A miss or a sweep never reports a port.
    `MLT_ASSERT(a_port_on_hit, clk, rst_n, out_valid && !out_data.ok |-> out_data.port_out == 16'd0, "port reported without a hit")

    // A successful learn or lookup removes nothing.
    `MLT_ASSERT(a_ok_no_removal, clk, rst_n, out_valid && out_data.ok |-> out_data.removed_count == 13'd0, "removal reported on learn or lookup")

    // Nothing is offered or taken while reset is held.
    `MLT_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !out_valid && !in_ready, "activity during reset")

endmodule

bind mac_learning_table mlt_checker u_mlt_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
);

`default_nettype wire
